FILE: hdl/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// ffpa_pkg
// Types and constants shared by the first-fit page allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

    localparam int MAX_RUNS  = 64;
    localparam int PAGE_BITS = 20;
    localparam int LEN_BITS  = PAGE_BITS + 1;
    localparam int END_BITS  = LEN_BITS + 1;
    localparam int IDX_BITS  = $clog2(MAX_RUNS);
    localparam int CNT_BITS  = $clog2(MAX_RUNS + 1);

    localparam logic OP_FREE  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic                 opcode;
        logic [PAGE_BITS-1:0] start_page;
        logic [LEN_BITS-1:0]  page_count;
        logic [LEN_BITS-1:0]  min_pages;
        logic [LEN_BITS-1:0]  max_pages;
    } ffpa_in_t;

    typedef struct packed {
        logic [PAGE_BITS-1:0] granted_start;
        logic [LEN_BITS-1:0]  granted_pages;
        logic [1:0]           status;
        logic [LEN_BITS-1:0]  free_pages_total;
    } ffpa_out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,      // issue read of entry
        S_CHECK,     // compare entry just read
        S_DECIDE,    // act on search result
        S_WRITE,     // final write, or read for the next insert shift
        S_SHL_WR,    // shift up for insert (top down)
        S_SHR_RD,    // shift down for removal (bottom up)
        S_SHR_WR,
        S_DONE
    } ffpa_state_t;

    function automatic logic [LEN_BITS-1:0] sat_add(input logic [LEN_BITS-1:0] a,
                                                    input logic [LEN_BITS-1:0] b);
        logic [LEN_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LEN_BITS] ? {LEN_BITS{1'b1}} : s[LEN_BITS-1:0];
    endfunction

endpackage

FILE: hdl/first_fit_page_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_page_allocator_top
// First-fit free-run table with coalescing on free and carving on allocate.
// ----------------------------------------------------------------------------
//  Channel | Signals                         | Direction
//  --------+---------------------------------+----------
//  in      | in_valid, in_ready, in_data     | into block
//  out     | out_valid, out_ready, out_data  | out of block
//
//  One item at a time. The run table is a memory with one read port and one
//  write port and registered read data, walked by one sequencer around one
//  shared comparator. A search issues the read of each entry looked at, then
//  compares it; an insert or a removal moves the tail one entry at a time, a
//  read then a write for each. Reset clears only the state, run count and
//  total; table contents need no clear. A result holds in the output register
//  until taken; in_ready stays low until then.
// ----------------------------------------------------------------------------
module first_fit_page_allocator_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ffpa_pkg::ffpa_in_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ffpa_pkg::ffpa_out_t  out_data
);
    import ffpa_pkg::*;

    // run table memory: start and length in one word
    logic [PAGE_BITS+LEN_BITS-1:0] mem [MAX_RUNS];
    logic [IDX_BITS-1:0]           rd_addr;
    logic [PAGE_BITS+LEN_BITS-1:0] rd_data_reg;
    logic                          wr_en;
    logic [IDX_BITS-1:0]           wr_addr;
    logic [PAGE_BITS+LEN_BITS-1:0] wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    wire [PAGE_BITS-1:0] rd_start = rd_data_reg[PAGE_BITS+LEN_BITS-1:LEN_BITS];
    wire [LEN_BITS-1:0]  rd_len   = rd_data_reg[LEN_BITS-1:0];

    ffpa_state_t          state_reg, state_next;
    ffpa_in_t             item_reg, item_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic [LEN_BITS-1:0]  total_reg, total_next;
    logic [CNT_BITS-1:0]  ptr_reg, ptr_next;       // scan / shift pointer
    logic [CNT_BITS-1:0]  pos_reg, pos_next;       // found position
    logic                 found_reg, found_next;
    logic [PAGE_BITS-1:0] cur_s_reg, cur_s_next;   // entry at pos
    logic [LEN_BITS-1:0]  cur_l_reg, cur_l_next;
    logic [PAGE_BITS-1:0] prev_s_reg, prev_s_next; // last entry passed (pos-1)
    logic [LEN_BITS-1:0]  prev_l_reg, prev_l_next;
    logic [PAGE_BITS-1:0] w_s_reg, w_s_next;       // word for final write
    logic [LEN_BITS-1:0]  w_l_reg, w_l_next;
    logic [IDX_BITS-1:0]  w_a_reg, w_a_next;
    logic                 w_en_reg, w_en_next;
    logic                 ins_reg, ins_next;       // shift up before write
    logic                 rem_reg, rem_next;       // remove entry pos after write
    ffpa_out_t            res_reg, res_next;

    // shared comparator and sequencing conditions
    logic                 hit;
    logic                 scan_end;
    logic                 zero_free;

    // decision on the search result
    logic [END_BITS-1:0]  prev_end;
    logic [END_BITS-1:0]  item_end;
    logic                 merge_lo;
    logic                 merge_hi;
    logic                 carve;
    logic [LEN_BITS-1:0]  grant;
    logic                 dec_act;
    logic                 dec_w_en;
    logic [IDX_BITS-1:0]  dec_w_a;
    logic [PAGE_BITS-1:0] dec_w_s;
    logic [LEN_BITS-1:0]  dec_w_l;
    logic                 dec_ins;
    logic                 dec_rem;
    logic [1:0]           dec_status;
    logic [PAGE_BITS-1:0] dec_gstart;
    logic [LEN_BITS-1:0]  dec_gpages;
    logic [LEN_BITS-1:0]  dec_total;

    assign scan_end  = (ptr_reg >= count_reg);
    assign zero_free = (in_data.opcode == OP_FREE) && (in_data.page_count == '0);

    // free: stop at the first start not below the new run
    // allocate: stop at the first run long enough
    always_comb
    begin
        if (item_reg.opcode == OP_FREE)
        begin
            hit = !(rd_start < item_reg.start_page);
        end
        else
        begin
            hit = !(rd_len < item_reg.min_pages);
        end
    end

    // Work out the table update and the result once the search has ended.
    // Run ends are one bit wider than a length, so they never wrap.
    always_comb
    begin
        prev_end = END_BITS'(prev_s_reg) + END_BITS'(prev_l_reg);
        item_end = END_BITS'(item_reg.start_page) + END_BITS'(item_reg.page_count);
        merge_lo = (pos_reg != '0) && (prev_end == END_BITS'(item_reg.start_page));
        merge_hi = found_reg && (item_end == END_BITS'(cur_s_reg));
        carve    = (item_reg.max_pages < cur_l_reg);
        grant    = carve ? item_reg.min_pages : cur_l_reg;

        dec_act    = 1'b0;
        dec_w_en   = 1'b0;
        dec_w_a    = pos_reg[IDX_BITS-1:0];
        dec_w_s    = cur_s_reg;
        dec_w_l    = cur_l_reg;
        dec_ins    = 1'b0;
        dec_rem    = 1'b0;
        dec_status = ST_OK;
        dec_gstart = '0;
        dec_gpages = '0;
        dec_total  = total_reg;

        if (item_reg.opcode == OP_ALLOC)
        begin
            if (!found_reg)
            begin
                dec_status = ST_NOFIT;
            end
            else
            begin
                dec_act    = 1'b1;
                dec_gstart = cur_s_reg;
                dec_gpages = grant;
                dec_total  = (total_reg > grant) ? total_reg - grant : '0;
                if (carve)
                begin
                    // carve from the front; drop the run if it empties
                    dec_w_s  = cur_s_reg + item_reg.min_pages[PAGE_BITS-1:0];
                    dec_w_l  = cur_l_reg - item_reg.min_pages;
                    dec_w_en = (cur_l_reg != item_reg.min_pages);
                    dec_rem  = (cur_l_reg == item_reg.min_pages);
                end
                else
                begin
                    dec_rem = 1'b1;
                end
            end
        end
        else if (merge_lo)
        begin
            // grow the predecessor, and swallow the follower if it touches
            dec_act   = 1'b1;
            dec_w_en  = 1'b1;
            dec_w_a   = pos_reg[IDX_BITS-1:0] - 1'b1;
            dec_w_s   = prev_s_reg;
            dec_w_l   = sat_add(prev_l_reg, item_reg.page_count);
            if (merge_hi)
            begin
                dec_w_l = sat_add(dec_w_l, cur_l_reg);
            end
            dec_rem   = merge_hi;
            dec_total = sat_add(total_reg, item_reg.page_count);
        end
        else if (merge_hi)
        begin
            dec_act   = 1'b1;
            dec_w_en  = 1'b1;
            dec_w_s   = item_reg.start_page;
            dec_w_l   = sat_add(cur_l_reg, item_reg.page_count);
            dec_total = sat_add(total_reg, item_reg.page_count);
        end
        else if (count_reg >= CNT_BITS'(MAX_RUNS))
        begin
            dec_status = ST_FULL;
        end
        else
        begin
            dec_act   = 1'b1;
            dec_w_en  = 1'b1;
            dec_w_s   = item_reg.start_page;
            dec_w_l   = item_reg.page_count;
            dec_ins   = 1'b1;
            dec_total = sat_add(total_reg, item_reg.page_count);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = zero_free ? S_DONE : S_SCAN;
                end
            end
            S_SCAN:   state_next = scan_end ? S_DECIDE : S_CHECK;
            S_CHECK:  state_next = hit ? S_DECIDE : S_SCAN;
            S_DECIDE: state_next = dec_act ? S_WRITE : S_DONE;
            S_WRITE:
            begin
                if (ins_reg && ptr_reg > pos_reg)
                begin
                    state_next = S_SHL_WR;
                end
                else if (rem_reg)
                begin
                    state_next = S_SHR_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SHL_WR: state_next = S_WRITE;
            S_SHR_RD: state_next = scan_end ? S_DONE : S_SHR_WR;
            S_SHR_WR: state_next = S_SHR_RD;
            S_DONE:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // data path
    always_comb
    begin
        item_next   = item_reg;
        count_next  = count_reg;
        total_next  = total_reg;
        ptr_next    = ptr_reg;
        pos_next    = pos_reg;
        found_next  = found_reg;
        cur_s_next  = cur_s_reg;
        cur_l_next  = cur_l_reg;
        prev_s_next = prev_s_reg;
        prev_l_next = prev_l_reg;
        w_s_next    = w_s_reg;
        w_l_next    = w_l_reg;
        w_a_next    = w_a_reg;
        w_en_next   = w_en_reg;
        ins_next    = ins_reg;
        rem_next    = rem_reg;
        res_next    = res_reg;
        rd_addr     = ptr_reg[IDX_BITS-1:0];
        wr_en       = 1'b0;
        wr_addr     = w_a_reg;
        wr_data     = {w_s_reg, w_l_reg};
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    ptr_next   = '0;
                    pos_next   = '0;
                    found_next = 1'b0;
                    res_next   = '0;
                    // zero-length free: report the total, touch nothing
                    res_next.free_pages_total = total_reg;
                end
            end
            S_SCAN:
            begin
                if (scan_end)
                begin
                    pos_next = count_reg;
                end
            end
            S_CHECK:
            begin
                if (hit)
                begin
                    found_next = 1'b1;
                    pos_next   = ptr_reg;
                    cur_s_next = rd_start;
                    cur_l_next = rd_len;
                end
                else
                begin
                    // remember the entry passed: it is the predecessor
                    prev_s_next = rd_start;
                    prev_l_next = rd_len;
                    ptr_next    = ptr_reg + 1'b1;
                end
            end
            S_DECIDE:
            begin
                w_s_next   = dec_w_s;
                w_l_next   = dec_w_l;
                w_a_next   = dec_w_a;
                w_en_next  = dec_w_en;
                ins_next   = dec_ins;
                rem_next   = dec_rem;
                ptr_next   = count_reg;
                total_next = dec_total;
                res_next.granted_start    = dec_gstart;
                res_next.granted_pages    = dec_gpages;
                res_next.status           = dec_status;
                res_next.free_pages_total = dec_total;
            end
            S_WRITE:
            begin
                if (ins_reg && ptr_reg > pos_reg)
                begin
                    // insert shift: fetch entry ptr-1
                    rd_addr = ptr_reg[IDX_BITS-1:0] - 1'b1;
                end
                else
                begin
                    wr_en = w_en_reg;
                    if (ins_reg)
                    begin
                        count_next = count_reg + 1'b1;
                        ins_next   = 1'b0;
                    end
                    if (rem_reg)
                    begin
                        ptr_next = pos_reg + 1'b1;
                    end
                end
            end
            // insert shift: entry ptr-1 moves to ptr
            S_SHL_WR:
            begin
                wr_en    = 1'b1;
                wr_addr  = ptr_reg[IDX_BITS-1:0];
                wr_data  = rd_data_reg;
                ptr_next = ptr_reg - 1'b1;
            end
            // removal shift: entry ptr moves to ptr-1
            S_SHR_RD:
            begin
                if (scan_end)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            S_SHR_WR:
            begin
                wr_en    = 1'b1;
                wr_addr  = ptr_reg[IDX_BITS-1:0] - 1'b1;
                wr_data  = rd_data_reg;
                ptr_next = ptr_reg + 1'b1;
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign out_data  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            total_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            total_reg <= total_next;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        ptr_reg    <= ptr_next;
        pos_reg    <= pos_next;
        found_reg  <= found_next;
        cur_s_reg  <= cur_s_next;
        cur_l_reg  <= cur_l_next;
        prev_s_reg <= prev_s_next;
        prev_l_reg <= prev_l_next;
        w_s_reg    <= w_s_next;
        w_l_reg    <= w_l_next;
        w_a_reg    <= w_a_next;
        w_en_reg   <= w_en_next;
        ins_reg    <= ins_next;
        rem_reg    <= rem_next;
        res_reg    <= res_next;
    end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives free and allocate items into the page allocator, predicts every
// result with a local copy of the run table, and compares the whole result word.
// ----------------------------------------------------------------------------
module tb;
    import ffpa_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    ffpa_in_t  in_data;
    logic      out_valid;
    logic      out_ready;
    ffpa_out_t out_data;

    first_fit_page_allocator_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Shadow of the run table, kept packed and sorted like the block's own.
    logic [PAGE_BITS-1:0] shadow_start [MAX_RUNS];
    logic [LEN_BITS-1:0]  shadow_len   [MAX_RUNS];
    int                   shadow_count;
    logic [LEN_BITS-1:0]  shadow_total;

    ffpa_out_t expected_results [$];
    int        errors;
    int        send_idle_pct;
    int        recv_stall_pct;
    bit        hold_off;
    int        quiet_cycles;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [LEN_BITS-1:0] clamp_add(logic [LEN_BITS-1:0] a,
                                                     logic [LEN_BITS-1:0] b);
        logic [LEN_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LEN_BITS] ? LEN_MAX : s[LEN_BITS-1:0];
    endfunction

    function automatic void drop_run(int idx);
        for (int i = idx; i + 1 < shadow_count; i++)
        begin
            shadow_start[i] = shadow_start[i+1];
            shadow_len[i]   = shadow_len[i+1];
        end
        shadow_count--;
    endfunction

    // Work out the result of one item and advance the shadow table.
    function automatic ffpa_out_t predict_alloc_result(ffpa_in_t it);
        ffpa_out_t r;
        int        p;
        bit        m_lo;
        bit        m_hi;
        r = '0;
        r.status = ST_OK;
        if (it.opcode == OP_FREE)
        begin
            if (it.page_count != 0)
            begin
                p = 0;
                while (p < shadow_count && shadow_start[p] < it.start_page)
                    p++;
                // Ends are compared without wrap: two bits wider than a page number.
                m_lo = 1'b0;
                if (p > 0)
                    m_lo = ({2'b0, shadow_start[p-1]} + {1'b0, shadow_len[p-1]})
                           == {2'b0, it.start_page};
                m_hi = 1'b0;
                if (p < shadow_count)
                    m_hi = ({2'b0, it.start_page} + {1'b0, it.page_count})
                           == {2'b0, shadow_start[p]};
                if (m_lo)
                begin
                    shadow_len[p-1] = clamp_add(shadow_len[p-1], it.page_count);
                    if (m_hi)
                    begin
                        shadow_len[p-1] = clamp_add(shadow_len[p-1], shadow_len[p]);
                        drop_run(p);
                    end
                end
                else if (m_hi)
                begin
                    shadow_start[p] = it.start_page;
                    shadow_len[p]   = clamp_add(shadow_len[p], it.page_count);
                end
                else if (shadow_count >= MAX_RUNS)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    for (int i = shadow_count; i > p; i--)
                    begin
                        shadow_start[i] = shadow_start[i-1];
                        shadow_len[i]   = shadow_len[i-1];
                    end
                    shadow_start[p] = it.start_page;
                    shadow_len[p]   = it.page_count;
                    shadow_count++;
                end
                if (r.status == ST_OK)
                    shadow_total = clamp_add(shadow_total, it.page_count);
            end
        end
        else
        begin
            p = 0;
            while (p < shadow_count && shadow_len[p] < it.min_pages)
                p++;
            if (p >= shadow_count)
                r.status = ST_NOFIT;
            else
            begin
                r.granted_start = shadow_start[p];
                if (it.max_pages < shadow_len[p])
                begin
                    r.granted_pages = it.min_pages;
                    shadow_start[p] = shadow_start[p] + it.min_pages[PAGE_BITS-1:0];
                    shadow_len[p]   = shadow_len[p] - it.min_pages;
                    if (shadow_len[p] == 0)
                        drop_run(p);
                end
                else
                begin
                    r.granted_pages = shadow_len[p];
                    drop_run(p);
                end
                shadow_total = (shadow_total > r.granted_pages)
                               ? shadow_total - r.granted_pages : '0;
            end
        end
        r.free_pages_total = shadow_total;
        return r;
    endfunction

    // Offer one item, hold it until accepted, predict its result.
    task automatic send_item(ffpa_in_t it);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        in_data  = it;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_results.push_back(predict_alloc_result(it));
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic send_free(logic [PAGE_BITS-1:0] s, logic [LEN_BITS-1:0] n);
        ffpa_in_t it;
        it = '0;
        it.opcode = OP_FREE;
        it.start_page = s;
        it.page_count = n;
        it.min_pages = LEN_BITS'($urandom);
        it.max_pages = LEN_BITS'($urandom);
        send_item(it);
    endtask

    task automatic send_alloc(logic [LEN_BITS-1:0] lo, logic [LEN_BITS-1:0] hi);
        ffpa_in_t it;
        it.opcode = OP_ALLOC;
        it.start_page = PAGE_BITS'($urandom);
        it.page_count = LEN_BITS'($urandom);
        it.min_pages = lo;
        it.max_pages = hi;
        send_item(it);
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    // Receiver: stall at random, compare each taken item with the oldest prediction.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, out_data);
                errors++;
            end
            else if (out_data !== expected_results[0])
            begin
                $display("%0t: mismatch expected %h actual %h (start/pages/status/total)",
                         $time, expected_results[0], out_data);
                errors++;
                void'(expected_results.pop_front());
            end
            else
                void'(expected_results.pop_front());
        end
    end

    // Watchdog on cycles with no handshake at all.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Edges of the fields, merges both sides, zero cases.
    task automatic test_directed();
        send_alloc(0, 0);                       // empty table fails
        send_free(20'd100, 0);                  // zero-length free ignored
        send_free(20'd100, 21'd10);
        send_free(20'd120, 21'd5);
        send_free(20'd110, 21'd10);             // joins both neighbours
        send_free(20'd90, 21'd10);              // merges after
        send_free(20'd125, 21'd3);              // merges before
        send_alloc(21'd4, 21'd100);             // whole run taken, no carve
        send_alloc(21'd0, 21'd0);               // table now empty, fails
        send_alloc(21'd1, LEN_MAX);             // table still empty, fails
        send_alloc(LEN_MAX, LEN_MAX);           // nothing fits
        send_free(20'hFFFFF, 21'd2);            // ends past top, no wrap merge
        send_free(20'd0, 21'd1);
        send_free(20'd1, LEN_MAX);              // saturating merge and total
        send_alloc(21'h100000, 21'd0);          // carve wraps start
        send_alloc(LEN_MAX, LEN_MAX);
        send_free(20'd0, 21'h100000);           // overlapping free
        send_alloc(21'd1, 21'd0);
        send_alloc(21'd1, 21'd0);
        wait_drained();
    endtask

    // Fill the table with isolated runs, then overflow it.
    task automatic test_table_full();
        for (int i = 0; i < MAX_RUNS + 3; i++)
            send_free(PAGE_BITS'(200000 + 4 * i), 21'd2);
        send_free(20'd199998, 21'd2);           // merge still works when full
        while (shadow_count > 0)
            send_alloc(21'd1, LEN_MAX);
        send_alloc(21'd1, LEN_MAX);
        wait_drained();
    endtask

    // Receiver holds off while the sender keeps offering items.
    task automatic test_back_pressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (600) @(negedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 8; i++)
                send_free(PAGE_BITS'(5000 + 10 * i), 21'd3);
        join
        wait_drained();
    endtask

    // Mostly well-formed traffic on a small page window, some wide noise.
    task automatic test_random(int count);
        int k;
        for (int i = 0; i < count; i++)
        begin
            k = $urandom_range(99);
            if (k < 45)
                send_free(PAGE_BITS'($urandom_range(2000)), LEN_BITS'($urandom_range(1, 40)));
            else if (k < 85)
                send_alloc(LEN_BITS'($urandom_range(0, 30)), LEN_BITS'($urandom_range(0, 60)));
            else if (k < 93)
                send_free(PAGE_BITS'($urandom), LEN_BITS'($urandom));
            else
                send_alloc(LEN_BITS'($urandom), LEN_BITS'($urandom));
        end
        wait_drained();
    endtask

    initial
    begin
        errors = 0;
        quiet_cycles = 0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        shadow_count = 0;
        shadow_total = '0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_table_full();
        test_back_pressure();
        test_random(310);
        send_idle_pct = 86;
        test_random(310);
        send_idle_pct = 0;
        recv_stall_pct = 86;
        test_random(310);
        send_idle_pct = 25;
        recv_stall_pct = 25;
        test_random(310);

        repeat (300) @(negedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
